FILE: rtl/core/dbs_pkg.sv
// ----------------------------------------------------------------------------
// Decimal bucket sort package
// Shared constants, types and the bucket selection function.
// ----------------------------------------------------------------------------
package dbs_pkg;

  localparam int unsigned MaxItems   = 64;
  localparam int unsigned NumBuckets = 10;
  localparam int unsigned TopBucket  = 9;
  localparam int unsigned ValW       = 7;
  localparam int unsigned BktW       = $clog2(NumBuckets);
  localparam int unsigned PosW       = $clog2(MaxItems);
  localparam int unsigned CntW       = $clog2(MaxItems + 1);
  localparam int unsigned AddrW      = BktW + PosW;
  localparam int unsigned MemDepth   = NumBuckets * MaxItems;

  localparam logic [1:0] RegDescending = 2'd0;

  typedef enum logic [2:0] {
    StIdle,
    StShiftRd,
    StShiftWr,
    StEmitRd,
    StEmitWait,
    StEmitOut
  } state_e;

  // Commands from controller to datapath.
  typedef struct packed {
    logic take;        // latch input, compute bucket, init position
    logic place;       // write value at current position, bump fill
    logic shift_rd;    // read entry at pos-1
    logic shift_wr;    // move read entry to pos, decrement pos
    logic emit_start;  // begin output sweep
    logic emit_rd;     // issue read of current output entry
    logic emit_adv;    // advance output cursor
    logic clear;       // clear fills and count
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic store_ok;    // item will be stored (count and fill not full)
    logic need_shift;  // pos > 0 and value < read entry (after shift_rd)
    logic pos_zero;    // insertion position is zero
    logic emit_done;   // no more entries to emit
    logic last_q;      // latched last mark
  } stat_t;

  function automatic logic [BktW-1:0] bucket_of(input logic [ValW-1:0] v);
    logic [BktW-1:0] b;
    if (v >= ValW'(90)) b = BktW'(TopBucket);
    else if (v >= ValW'(80)) b = BktW'(8);
    else if (v >= ValW'(70)) b = BktW'(7);
    else if (v >= ValW'(60)) b = BktW'(6);
    else if (v >= ValW'(50)) b = BktW'(5);
    else if (v >= ValW'(40)) b = BktW'(4);
    else if (v >= ValW'(30)) b = BktW'(3);
    else if (v >= ValW'(20)) b = BktW'(2);
    else if (v >= ValW'(10)) b = BktW'(1);
    else b = BktW'(0);
    return b;
  endfunction

endpackage

FILE: rtl/core/dbs_stream_if.sv
// ----------------------------------------------------------------------------
// Valid/ready stream interfaces
// Input and output channels of the decimal bucket sort.
// ----------------------------------------------------------------------------
interface dbs_in_if;
  logic       valid;
  logic       ready;
  logic [6:0] value;
  logic       last_in;
  modport source (output valid, output value, output last_in, input ready);
  modport sink   (input valid, input value, input last_in, output ready);
endinterface

interface dbs_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] sorted_value;
  logic       last_out;
  modport source (output valid, output sorted_value, output last_out, input ready);
  modport sink   (input valid, input sorted_value, input last_out, output ready);
endinterface

FILE: rtl/core/dbs_datapath.sv
// ----------------------------------------------------------------------------
// Decimal bucket sort datapath
// Bucket memory, fill counters, insertion cursor and output cursor.
// ----------------------------------------------------------------------------
module dbs_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  dbs_pkg::cmd_t              cmd_i,
  input  logic [dbs_pkg::ValW-1:0]   value_i,
  input  logic                       last_i,
  input  logic                       descending_i,
  output dbs_pkg::stat_t             stat_o,
  output logic [dbs_pkg::ValW-1:0]   out_value_o,
  output logic                       out_last_o,
  output logic                       skip_o
);
  import dbs_pkg::*;

  logic [ValW-1:0] mem [MemDepth];
  logic [ValW-1:0] rd_q;

  logic [CntW-1:0] fill_q [NumBuckets];
  logic [CntW-1:0] count_q;
  logic [ValW-1:0] val_q;
  logic            last_q;
  logic [BktW-1:0] bkt_q;
  logic [PosW-1:0] pos_q;
  logic            ok_q;

  // Output cursor.
  logic [BktW-1:0] ob_q;
  logic [CntW-1:0] oj_q;
  logic [CntW-1:0] on_q;
  logic [CntW-1:0] total_q;

  logic [CntW-1:0] ofill;
  logic [PosW-1:0] oidx;
  logic            bkt_end;
  logic            last_bkt;
  logic [BktW-1:0] nb;
  logic [PosW-1:0] posm1;
  logic [AddrW:0]  wr_addr_w;
  logic [AddrW:0]  rd_addr_w;
  logic [AddrW-1:0] wr_addr;
  logic [AddrW-1:0] rd_addr;
  logic            wr_en;
  logic            rd_en;
  logic [ValW-1:0] wr_data;
  logic [BktW-1:0] in_bkt;

  assign in_bkt  = bucket_of(value_i);
  assign posm1   = pos_q - PosW'(1);
  assign ofill   = fill_q[ob_q];
  assign oidx    = descending_i ? PosW'(ofill - oj_q - CntW'(1)) : PosW'(oj_q);
  assign bkt_end = (oj_q >= ofill);
  assign last_bkt = descending_i ? (ob_q == BktW'(0)) : (ob_q == BktW'(TopBucket));
  assign nb      = descending_i ? (ob_q - BktW'(1)) : (ob_q + BktW'(1));

  always_comb begin
    wr_en   = cmd_i.place | cmd_i.shift_wr;
    wr_data = cmd_i.place ? val_q : rd_q;
    wr_addr_w = ({1'b0, AddrW'(bkt_q)} * (AddrW + 1)'(MaxItems)) + (AddrW + 1)'(pos_q);
    rd_en   = cmd_i.shift_rd | cmd_i.emit_rd;
    if (cmd_i.emit_rd) begin
      rd_addr_w = ({1'b0, AddrW'(ob_q)} * (AddrW + 1)'(MaxItems)) + (AddrW + 1)'(oidx);
    end else begin
      rd_addr_w = ({1'b0, AddrW'(bkt_q)} * (AddrW + 1)'(MaxItems)) + (AddrW + 1)'(posm1);
    end
    wr_addr = wr_addr_w[AddrW-1:0];
    rd_addr = rd_addr_w[AddrW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      val_q  <= value_i;
      last_q <= last_i;
      bkt_q  <= in_bkt;
      pos_q  <= PosW'(fill_q[in_bkt]);
    end else if (cmd_i.shift_wr) begin
      pos_q <= posm1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumBuckets; i++) fill_q[i] <= '0;
      count_q <= '0;
      ok_q    <= 1'b0;
      ob_q    <= '0;
      oj_q    <= '0;
      on_q    <= '0;
      total_q <= '0;
    end else begin
      if (cmd_i.take) begin
        ok_q <= (count_q < CntW'(MaxItems)) && (fill_q[in_bkt] < CntW'(MaxItems));
        if (count_q < CntW'(MaxItems)) count_q <= count_q + CntW'(1);
      end
      if (cmd_i.place) fill_q[bkt_q] <= fill_q[bkt_q] + CntW'(1);
      if (cmd_i.emit_start) begin
        ob_q    <= descending_i ? BktW'(TopBucket) : '0;
        oj_q    <= '0;
        on_q    <= '0;
        total_q <= count_q;
      end else if (cmd_i.emit_rd && !bkt_end) begin
        on_q <= on_q + CntW'(1);
      end else if (cmd_i.emit_adv) begin
        if (bkt_end) begin
          ob_q <= nb;
          oj_q <= '0;
        end else begin
          oj_q <= oj_q + CntW'(1);
        end
      end
      if (cmd_i.clear) begin
        for (int i = 0; i < NumBuckets; i++) fill_q[i] <= '0;
        count_q <= '0;
      end
    end
  end

  assign stat_o.store_ok   = ok_q;
  assign stat_o.need_shift = (pos_q != '0) && (val_q < rd_q);
  assign stat_o.pos_zero   = (pos_q == '0);
  assign stat_o.emit_done  = (on_q >= total_q) || (bkt_end && last_bkt);
  assign stat_o.last_q     = last_q;

  assign out_value_o = rd_q;
  assign out_last_o  = (on_q == total_q);

  // The current output bucket is exhausted and the sweep moves to the next.
  assign skip_o = bkt_end;

endmodule

FILE: rtl/core/dbs_controller.sv
// ----------------------------------------------------------------------------
// Decimal bucket sort controller
// Sequences insertion, output sweep and clearing of the bucket state.
// ----------------------------------------------------------------------------
module dbs_controller (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  dbs_pkg::stat_t  stat_i,
  input  logic            emit_skip_i,
  output dbs_pkg::cmd_t   cmd_o
);
  import dbs_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) state_d = StShiftRd;
      end
      StShiftRd: begin
        if (!stat_i.store_ok || stat_i.pos_zero) begin
          state_d = stat_i.last_q ? StEmitRd : StIdle;
        end else begin
          state_d = StShiftWr;
        end
      end
      StShiftWr: begin
        if (stat_i.need_shift) state_d = StShiftRd;
        else state_d = stat_i.last_q ? StEmitRd : StIdle;
      end
      StEmitRd: begin
        if (stat_i.emit_done) state_d = StIdle;
        else if (emit_skip_i) state_d = StEmitRd;
        else state_d = StEmitWait;
      end
      StEmitWait: state_d = StEmitOut;
      StEmitOut: begin
        if (out_ready_i) state_d = StEmitRd;
      end
      default: state_d = StIdle;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o  = 1'b1;
        cmd_o.take  = in_valid_i;
      end
      StShiftRd: begin
        if (stat_i.store_ok && stat_i.pos_zero) cmd_o.place = 1'b1;
        if (stat_i.store_ok && !stat_i.pos_zero) cmd_o.shift_rd = 1'b1;
        cmd_o.emit_start = stat_i.last_q && (!stat_i.store_ok || stat_i.pos_zero);
      end
      StShiftWr: begin
        if (stat_i.need_shift) cmd_o.shift_wr = 1'b1;
        else cmd_o.place = 1'b1;
        cmd_o.emit_start = stat_i.last_q && !stat_i.need_shift;
      end
      StEmitRd: begin
        if (stat_i.emit_done) cmd_o.clear = 1'b1;
        else if (emit_skip_i) cmd_o.emit_adv = 1'b1;
        else cmd_o.emit_rd = 1'b1;
      end
      StEmitWait: ;
      StEmitOut: begin
        out_valid_o    = 1'b1;
        cmd_o.emit_adv = out_ready_i;
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/core/decimal_bucket_sort.sv
// ----------------------------------------------------------------------------
// Decimal bucket sort
// Collects a list of values, sorts it by tens-digit buckets and streams it out.
// ----------------------------------------------------------------------------
// Values arrive on the input channel one transaction at a time; last_in marks
// the final one. Each value is insertion-sorted into one of ten buckets held
// in a single-port style bucket memory, one entry moved at a time by a read
// and then a write, until a smaller or equal entry or the bucket start ends
// the walk; bucket 9 takes all values of 90 and up. After the marked item
// the whole list leaves on the output channel, ascending or descending as
// the descending register reads during the sweep, with last_out on the
// final element. Each output element takes a read, a wait and a present
// step, and every bucket boundary passed, empty or not, adds a skip step.
// Items beyond 64 are dropped, though a final mark on such an item still
// starts the output.
// While the list is being emitted no input is taken. If the receiver stalls,
// the present element simply holds until it is taken. Reset empties all
// buckets and the item count and sets ascending order; the memory itself is
// never cleared, since only entries below a bucket's fill are ever read.
// The register is written through the APB-style port, address 0.
// ----------------------------------------------------------------------------
module decimal_bucket_sort (
  input  logic        clk_i,
  input  logic        rst_ni,
  dbs_in_if.sink      in_i,
  dbs_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import dbs_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  descending_q;
  logic  cfg_wr;
  logic  emit_skip;
  logic  out_valid;
  logic  in_ready;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == RegDescending);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      descending_q <= 1'b0;
    end else if (cfg_wr) begin
      descending_q <= pwdata[0];
    end
  end

  assign prdata = (paddr == RegDescending) ? {31'd0, descending_q} : 32'd0;

  dbs_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .emit_skip_i (emit_skip),
    .cmd_o       (cmd)
  );

  logic [ValW-1:0] out_val;
  logic            out_last;

  dbs_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .value_i      (in_i.value),
    .last_i       (in_i.last_in),
    .descending_i (descending_q),
    .stat_o       (stat),
    .out_value_o  (out_val),
    .out_last_o   (out_last),
    .skip_o       (emit_skip)
  );

  assign in_i.ready         = in_ready;
  assign out_o.valid        = out_valid;
  assign out_o.sorted_value = out_val;
  assign out_o.last_out     = out_last;

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready && out_valid)) else $error("input taken during output");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_o.ready |=> out_valid && $stable(out_val))
    else $error("stalled output changed");
  a_cmd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.place && cmd.shift_wr)) else $error("two memory writes at once");
`endif

endmodule
